/* rtl/core/hclt_pkg.sv */
// Shared types and constants for the hill-climb load tracker core.
// Used by hclt_ctrl, hclt_datapath and hill_climb_load_tracker_core.
`default_nettype none

package hclt_pkg;

   localparam int POWER_W         = 28;
   localparam int POWER_MAX       = 268435455;
   localparam int PATTERN_OUT_W   = 8;
   localparam int PATTERN_OUT_MAX = 255;
   localparam int RES_UNIT        = 100;  // centiohm of stage 0 when open
   localparam int RES_CLOSED      = 2;    // centiohm of a closed bypass
   localparam int RES_EXTRA_W     = 7;    // bits needed for the factor RES_UNIT
   localparam int SQUARE_SHIFT    = 8;    // sample squared is scaled by 256

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_DIVIDE,
      ST_COMMIT
   } hclt_state_type;

   typedef struct packed {
      logic capture;   // take the sample of an accepted item
      logic prep;      // form the square and the load resistance
      logic div_step;  // one restoring division step
      logic commit;    // update the tracker state and load the result
   } hclt_cmd_type;

   typedef struct packed {
      logic div_done;  // the current division step is the last one
   } hclt_status_type;

endpackage

`default_nettype wire

/* rtl/core/hill_climb_load_tracker_core.sv */
// Perturb-and-observe load tracker driving a binary resistor cascade.
// An accepted item passes the square, divide and commit states before its result is offered;
// the divide state runs the serial divider, which produces one quotient bit per cycle.
// A new item is taken only when idle; the next item may enter while a result waits.
// Reset (synchronous, active high): all bypasses closed if STAGES <= 8, direction set, power zero.
`default_nettype none

module hill_climb_load_tracker_core #(
   parameter int STAGES   = 8,
   parameter int ADC_BITS = 12
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [ADC_BITS-1:0]           req_adc_sample,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [hclt_pkg::PATTERN_OUT_W-1:0] rsp_switch_pattern,
   output logic [hclt_pkg::POWER_W-1:0]       rsp_power_metric,
   output logic                               rsp_toward_high_resistance
);
   import hclt_pkg::*;

   hclt_cmd_type    cmd;
   hclt_status_type status;

   hclt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   hclt_datapath #(
      .STAGES   (STAGES),
      .ADC_BITS (ADC_BITS)
   ) u_datapath (
      .clock                      (clock),
      .reset                      (reset),
      .cmd                        (cmd),
      .req_adc_sample             (req_adc_sample),
      .status                     (status),
      .rsp_switch_pattern         (rsp_switch_pattern),
      .rsp_power_metric           (rsp_power_metric),
      .rsp_toward_high_resistance (rsp_toward_high_resistance)
   );

`ifndef SYNTHESIS
   // A waiting result is never overwritten.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid || rsp_ready))
      else $error("result overwritten while still offered");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.prep, cmd.div_step, cmd.commit}))
      else $error("more than one datapath command at once");

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid)
      else $error("committed item not offered as a result");

   // An accepted item needs the full division before its result can commit.
   a_no_early_commit: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !cmd.commit ##1 !cmd.commit)
      else $error("result committed too early after acceptance");
`endif

endmodule

`default_nettype wire

/* rtl/core/hclt_ctrl.sv */
// Sequencing state machine of the tracker core and the result valid flag.
// Depends on hclt_pkg for the state, command and status types.
`default_nettype none

module hclt_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   input  wire hclt_pkg::hclt_status_type status,
   output hclt_pkg::hclt_cmd_type        cmd
);
   import hclt_pkg::*;

   hclt_state_type state_ff;
   hclt_state_type state_in;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   logic           out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_SQUARE: begin
            cmd.prep = 1'b1;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         ST_COMMIT: begin
            cmd.commit = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // A result stays offered until it is taken; a new one may replace it in the same cycle.
   assign rsp_valid_in = cmd.commit || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/hclt_datapath.sv */
// Datapath of the tracker core: square, load resistance, serial divider,
// hill-climb state and the result registers. Depends on hclt_pkg.
`default_nettype none

module hclt_datapath #(
   parameter int STAGES   = 8,
   parameter int ADC_BITS = 12
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire hclt_pkg::hclt_cmd_type        cmd,
   input  wire logic [ADC_BITS-1:0]           req_adc_sample,
   output hclt_pkg::hclt_status_type          status,
   output logic [hclt_pkg::PATTERN_OUT_W-1:0] rsp_switch_pattern,
   output logic [hclt_pkg::POWER_W-1:0]       rsp_power_metric,
   output logic                               rsp_toward_high_resistance
);
   import hclt_pkg::*;

   localparam int SQ_W    = 2 * ADC_BITS;
   localparam int NUM_W   = SQ_W + SQUARE_SHIFT;
   localparam int RES_W   = STAGES + RES_EXTRA_W;
   localparam int CNT_W   = $clog2(NUM_W);
   localparam int POP_W   = $clog2(STAGES + 1);
   localparam int QW      = (NUM_W > POWER_W) ? NUM_W : POWER_W;
   localparam int PW      = (STAGES > PATTERN_OUT_W) ? STAGES : PATTERN_OUT_W;
   localparam logic [STAGES-1:0] PATTERN_RESET = STAGES'(PATTERN_OUT_MAX);

   logic [ADC_BITS-1:0]      sample_ff;
   logic [NUM_W-1:0]         num_ff;
   logic [RES_W-1:0]         res_ff;
   logic [RES_W:0]           rem_ff;
   logic [NUM_W-1:0]         quo_ff;
   logic [CNT_W-1:0]         cnt_ff;
   logic [STAGES-1:0]        pattern_ff;
   logic [STAGES-1:0]        pattern_in;
   logic                     dir_ff;
   logic                     dir_in;
   logic [POWER_W-1:0]       last_power_ff;
   logic [PATTERN_OUT_W-1:0] out_pattern_ff;
   logic [POWER_W-1:0]       out_power_ff;
   logic                     out_dir_ff;

   logic [SQ_W-1:0]          square;
   logic [POP_W-1:0]         closed_cnt;
   logic [RES_W-1:0]         res_in;
   logic [RES_W:0]           shifted;
   logic                     fits;
   logic [RES_W:0]           rem_in;
   logic [QW-1:0]            quo_ext;
   logic [POWER_W-1:0]       power;
   logic [STAGES-1:0]        pattern_up;
   logic [STAGES-1:0]        pattern_down;
   logic [PW-1:0]            pattern_ext;

   assign square = SQ_W'(sample_ff) * SQ_W'(sample_ff);

   // Open stage i adds 100 << i, which summed over all open stages is 100 times
   // the inverted pattern; each closed bypass adds 2.
   always_comb begin
      closed_cnt = '0;
      for (int i = 0; i < STAGES; i++) begin
         closed_cnt = closed_cnt + POP_W'(pattern_ff[i]);
      end
   end

   assign res_in = {{RES_EXTRA_W{1'b0}}, ~pattern_ff} * RES_W'(RES_UNIT)
                 + RES_W'(closed_cnt) * RES_W'(RES_CLOSED);

   // Restoring division, one quotient bit per step, dividend bits from the top.
   assign shifted = {rem_ff[RES_W-1:0], num_ff[NUM_W-1]};
   assign fits    = shifted >= {1'b0, res_ff};
   assign rem_in  = fits ? (shifted - {1'b0, res_ff}) : shifted;

   assign quo_ext = QW'(quo_ff);
   assign power   = (quo_ext > QW'(POWER_MAX)) ? POWER_W'(POWER_MAX) : quo_ext[POWER_W-1:0];

   assign pattern_up   = (&pattern_ff) ? pattern_ff : pattern_ff + STAGES'(1);
   assign pattern_down = (pattern_ff == '0) ? pattern_ff : pattern_ff - STAGES'(1);

   always_comb begin
      pattern_in = pattern_ff;
      dir_in     = dir_ff;
      if (power > last_power_ff) begin
         pattern_in = dir_ff ? pattern_down : pattern_up;
      end else if (power < last_power_ff) begin
         pattern_in = dir_ff ? pattern_up : pattern_down;
         dir_in     = !dir_ff;
      end
   end

   assign pattern_ext = PW'(pattern_in);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_ff <= req_adc_sample;
      end
      if (cmd.prep) begin
         num_ff <= {square, {SQUARE_SHIFT{1'b0}}};
         res_ff <= res_in;
         rem_ff <= '0;
         quo_ff <= '0;
         cnt_ff <= CNT_W'(NUM_W - 1);
      end else if (cmd.div_step) begin
         num_ff <= {num_ff[NUM_W-2:0], 1'b0};
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[NUM_W-2:0], fits};
         cnt_ff <= cnt_ff - CNT_W'(1);
      end
      if (cmd.commit) begin
         out_pattern_ff <= pattern_ext[PATTERN_OUT_W-1:0];
         out_power_ff   <= power;
         out_dir_ff     <= dir_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff    <= PATTERN_RESET;
         dir_ff        <= 1'b1;
         last_power_ff <= '0;
      end else if (cmd.commit) begin
         pattern_ff    <= pattern_in;
         dir_ff        <= dir_in;
         last_power_ff <= power;
      end
   end

   assign status.div_done            = (cnt_ff == '0);
   assign rsp_switch_pattern         = out_pattern_ff;
   assign rsp_power_metric           = out_power_ff;
   assign rsp_toward_high_resistance = out_dir_ff;

endmodule

`default_nettype wire
